// ===== src/tmra_pkg.sv =====
package tmra_pkg;

   // payload widths of the channels and the register
   localparam int SAMPLE_W = 12;
   localparam int COUNT_W  = 4;

   // lowest sample code, also the ring contents after reset
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 12'sh800;

   // default ring depth and the number of entries dropped from a full ring
   localparam int DEF_RING_DEPTH = 8;
   localparam int TRIM_DROP      = 2;

endpackage

// ===== src/tmra_if.sv =====
// sample word in
interface tmra_req_if;
   import tmra_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

// average word out
interface tmra_rsp_if;
   import tmra_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] average;
   logic        [COUNT_W-1:0]  valid_count;

   modport source (output valid, output average, output valid_count, input ready);
   modport sink (input valid, input average, input valid_count, output ready);
endinterface

// ===== src/tmra_ring.sv =====
module tmra_ring #(
   parameter int RING_DEPTH = tmra_pkg::DEF_RING_DEPTH,
   parameter int IDX_W      = $clog2(RING_DEPTH)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic signed [tmra_pkg::SAMPLE_W-1:0] wr_data,
   input  logic        [IDX_W-1:0]              rd_idx,
   output logic signed [tmra_pkg::SAMPLE_W-1:0] rd_data
);
   import tmra_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

   logic signed [SAMPLE_W-1:0] ring_ff [RING_DEPTH];
   logic        [IDX_W-1:0]    wptr_ff;
   logic        [IDX_W-1:0]    wptr_in;

   // write pointer wraps after the last slot
   always_comb begin
      wptr_in = wptr_ff;
      if (wr_en) begin
         wptr_in = (wptr_ff == LAST_IDX) ? '0 : wptr_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= SAMPLE_MIN;
         end
      end else begin
         wptr_ff <= wptr_in;
         if (wr_en) begin
            ring_ff[wptr_ff] <= wr_data;
         end
      end
   end

   // single read port for the walk
   assign rd_data = ring_ff[rd_idx];

endmodule

// ===== src/tmra_div.sv =====
module tmra_div #(
   parameter int SUM_W = 15,
   parameter int CNT_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);
   localparam int STEP_W = $clog2(SUM_W + 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W:0]   trial;
   logic [CNT_W:0]   diff;
   logic             fits;

   // one restoring step a cycle, dividend bits shift out as quotient bits shift in
   always_comb begin
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      fits    = (trial >= {1'b0, dsr_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/trimmed_mean_ring_average.sv =====
// channel   dir  handshake          payload
// req_chan  in   valid/ready        sample (s12, 1/16 deg)
// rsp_chan  out  valid/ready        average (s12), valid_count (u4)
// csr       in   csr_we, no ready   csr_wdata -> valid floor (s12)
//
// one word at a time: after the accepting edge, a walk over all RING_DEPTH entries with one
// compare/add unit, a setup step, a divider launch step, SUM_W divider steps
// and a step to take the quotient; the divider is skipped when fewer than two
// entries are valid, and the setup step then takes the accepted word as the result
// synchronous reset fills the ring with the lowest code and the floor as well
// req ready stays low until the result word is taken, next word the cycle after
module trimmed_mean_ring_average #(
   parameter int RING_DEPTH = tmra_pkg::DEF_RING_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   tmra_req_if.sink                             req_chan,
   tmra_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic signed [tmra_pkg::SAMPLE_W-1:0] csr_wdata
);
   import tmra_pkg::*;

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int SUM_W = SAMPLE_W + $clog2(RING_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(RING_DEPTH);
   localparam logic [CNT_W-1:0] TRIM_DIV  = CNT_W'(RING_DEPTH - TRIM_DROP);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_WALK = 5'b00010,
      ST_PREP = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   logic signed [SAMPLE_W-1:0] floor_ff;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic        [IDX_W-1:0]    idx_ff, idx_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_W-1:0] lo_ff, lo_in;
   logic signed [SAMPLE_W-1:0] hi_ff, hi_in;
   logic        [CNT_W-1:0]    count_ff, count_in;
   logic        [SUM_W-1:0]    mag_ff, mag_in;
   logic        [CNT_W-1:0]    dsr_ff, dsr_in;
   logic                       neg_ff, neg_in;
   logic signed [SAMPLE_W-1:0] avg_ff, avg_in;
   logic                       launch_ff;
   logic                       div_start;
   logic                       div_done;
   logic        [SUM_W-1:0]    div_quo;
   logic        [SUM_W-1:0]    quo_signed;
   logic signed [SAMPLE_W-1:0] entry;
   logic signed [SUM_W-1:0]    entry_ext;
   logic signed [SUM_W-1:0]    lo_ext;
   logic signed [SUM_W-1:0]    hi_ext;
   logic signed [SUM_W-1:0]    numer;
   logic        [31:0]         count_wide;
   logic                       req_fire;
   logic                       rsp_fire;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   // ring storage and write pointer
   tmra_ring #(
      .RING_DEPTH (RING_DEPTH),
      .IDX_W      (IDX_W)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_fire),
      .wr_data (req_chan.sample),
      .rd_idx  (idx_ff),
      .rd_data (entry)
   );

   // serial magnitude divider
   tmra_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_ff),
      .divisor  (dsr_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // sign extension for the accumulator
   assign entry_ext = {{(SUM_W - SAMPLE_W){entry[SAMPLE_W-1]}}, entry};
   assign lo_ext    = {{(SUM_W - SAMPLE_W){lo_ff[SAMPLE_W-1]}}, lo_ff};
   assign hi_ext    = {{(SUM_W - SAMPLE_W){hi_ff[SAMPLE_W-1]}}, hi_ff};

   // full ring drops one low and one high entry
   assign numer      = (count_ff == FULL_CNT) ? (sum_ff - lo_ext - hi_ext) : sum_ff;
   assign quo_signed = neg_ff ? (~div_quo + SUM_W'(1)) : div_quo;

   // sequencer and accumulate unit
   always_comb begin
      state_in  = state_ff;
      sample_in = sample_ff;
      idx_in    = idx_ff;
      sum_in    = sum_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      count_in  = count_ff;
      mag_in    = mag_ff;
      dsr_in    = dsr_ff;
      neg_in    = neg_ff;
      avg_in    = avg_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sample_in = req_chan.sample;
               idx_in    = '0;
               sum_in    = '0;
               count_in  = '0;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            if (entry > floor_ff) begin
               sum_in   = sum_ff + entry_ext;
               count_in = count_ff + ONE_CNT;
               if (count_ff == '0) begin
                  lo_in = entry;
                  hi_in = entry;
               end else begin
                  if (entry < lo_ff) lo_in = entry;
                  if (entry > hi_ff) hi_in = entry;
               end
            end
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            neg_in = numer[SUM_W-1];
            mag_in = numer[SUM_W-1] ? (~numer + SUM_W'(1)) : numer;
            dsr_in = (count_ff == FULL_CNT) ? TRIM_DIV : count_ff;
            if (count_ff > ONE_CNT) begin
               state_in = ST_DIV;
            end else begin
               avg_in   = sample_ff;
               state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            // first divide cycle starts the divider
            div_start = launch_ff;
            if (div_done) begin
               avg_in   = quo_signed[SAMPLE_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // the divider is launched in the cycle after setup, once its operands are registered
   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff <= 1'b0;
      end else begin
         launch_ff <= (state_ff == ST_PREP) && (count_ff > ONE_CNT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         floor_ff <= SAMPLE_MIN;
         idx_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
         if (csr_we) begin
            floor_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      sum_ff    <= sum_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mag_ff    <= mag_in;
      dsr_ff    <= dsr_in;
      neg_ff    <= neg_in;
      avg_ff    <= avg_in;
   end

   // channel outputs
   assign count_wide           = 32'(count_ff);
   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = (state_ff == ST_OUT);
   assign rsp_chan.average     = avg_ff;
   assign rsp_chan.valid_count = count_wide[COUNT_W-1:0];

`ifndef NO_ASSERTIONS
   // no new word is taken while a result is pending
   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("input accepted while result pending");

   // an accepted word always starts a ring walk
   a_accept_walks: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_WALK) && (idx_ff == '0) && (count_ff == '0))
      else $error("accepted word did not start a walk");

   // the valid count of a pending result never exceeds the ring depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (count_ff <= FULL_CNT))
      else $error("valid count above ring depth");

   // the divider only reports while a division is in progress
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide phase");
`endif

endmodule
